// File: hw/rtl/kmp_pkg.sv
// Shared types and constants for the streaming KMP substring matcher.
package kmp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 4;   // matched prefix length / table entry
  localparam int unsigned LEN_W  = 5;   // pattern length register
  localparam int unsigned PAT_W  = 128; // two 64-bit pattern registers
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned IDX_W  = 2;   // configuration register index

  typedef enum logic [IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_BUILD  = 4'b0010,
    ST_MATCH  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] addr;
    logic [CNT_W-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0] idx_a;
    logic [CNT_W-1:0] idx_b;
    logic             use_text;
  } cmp_req_t;

endpackage

// File: hw/rtl/kmp_fail_table.sv
// Generic RAM: one write port, one read port with registered read data.
module kmp_fail_table #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/kmp_cmp_unit.sv
// Shared byte comparator: pattern byte vs. pattern byte or text byte.
module kmp_cmp_unit (
  input  logic [kmp_pkg::PAT_W-1:0]  pattern_i,
  input  logic [kmp_pkg::BYTE_W-1:0] text_i,
  input  kmp_pkg::cmp_req_t          req_i,
  output logic                       eq_o
);
  import kmp_pkg::*;

  logic [BYTE_W-1:0] byte_a;
  logic [BYTE_W-1:0] byte_b;

  assign byte_a = pattern_i[req_i.idx_a*BYTE_W +: BYTE_W];
  assign byte_b = req_i.use_text ? text_i : pattern_i[req_i.idx_b*BYTE_W +: BYTE_W];
  assign eq_o   = (byte_a == byte_b);

endmodule

// File: hw/rtl/kmp_substring_matcher.sv
// Streaming Knuth-Morris-Pratt substring matcher, top level and sequencer.
//
// Usage: write the pattern through the cfg channel (index 0: bytes 0..7,
// index 1: bytes 8..15, index 2: length 1..MAX_PATTERN), only while idle.
// Text bytes arrive on s_axis (tdata = byte, tlast = final byte of a text).
// One result beat per text byte leaves on m_axis, tlast echoing the input.
// Sequence: a byte is taken in the idle state, passes through the compare
// loop (a compare step plus any fallback steps) and then the result stage,
// which loads its beat into the output register; the next byte can be taken
// once that beat is loaded. The first byte after reset, after a config write
// or after a tlast beat first builds the failure table; for a pattern of
// length n the build takes at most n - 1 fallback steps. The single byte
// comparator and the one registered read port of the failure table limit
// each step of either loop to one comparison and one table read.
// s_axis_tready is high only while the sequencer is idle; one byte is in
// work at a time. The output register holds a result while m_axis stalls;
// the next byte may be taken and worked on meanwhile, but its result waits.
// Reset clears the matched length, the found flag, the table-valid flag and
// the output valid; the pattern resets to one zero byte. The tlast beat's
// result shows the state before the text state clears.
module kmp_substring_matcher #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [kmp_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [kmp_pkg::CFG_W-1:0] cfg_data_i,
  // text input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] text_byte
  input  logic        s_axis_tlast,  // text_last
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [0] match_end, [1] found_any,
                                     // [5:2] prefix_matched, [7:6] zero
  output logic        m_axis_tlast   // text_done
);
  import kmp_pkg::*;

  localparam int unsigned TBL_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  state_e state_q, state_d;

  logic [CFG_W-1:0]  pat_low_q, pat_high_q;
  logic [LEN_W-1:0]  pat_len_q;
  logic [PAT_W-1:0]  pattern;
  logic [LEN_W-1:0]  eff_len;

  logic [CNT_W-1:0]  mc_q, mc_d;
  logic              found_q, found_d;
  logic              tbl_ok_q, tbl_ok_d;

  logic [BYTE_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic [LEN_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  j_q, j_d;
  logic              hit_q, hit_d;
  logic [CNT_W-1:0]  j_fin;

  logic              out_vld_q, out_vld_d;
  logic              out_hit_q, out_found_q, out_last_q;
  logic [CNT_W-1:0]  out_len_q;
  logic              out_load;

  tbl_wr_t           tbl_wr;
  logic [CNT_W-1:0]  tbl_raddr, tbl_rdata;
  cmp_req_t          cmp_req;
  logic              eq;

  logic [LEN_W-1:0]  kn, jn, len_m1;
  logic [CNT_W-1:0]  mc_start;
  logic              in_acc, cfg_acc;

  assign pattern = {pat_high_q, pat_low_q};

  always_comb begin
    if (pat_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (pat_len_q > LEN_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pat_len_q;
    end
  end

  assign len_m1   = eff_len - LEN_W'(1);
  assign mc_start = ({1'b0, mc_q} >= eff_len) ? '0 : mc_q;
  assign kn       = {1'b0, k_q} + LEN_W'(eq);
  assign jn       = {1'b0, j_q} + LEN_W'(eq);
  // after a full occurrence the table read of the last entry is waiting
  assign j_fin    = hit_q ? tbl_rdata : j_q;

  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= LEN_W'(1);
    end else if (cfg_acc) begin
      case (cfg_index_i)
        REG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        REG_PAT_HIGH: pat_high_q <= cfg_data_i;
        REG_PAT_LEN:  pat_len_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  kmp_cmp_unit u_cmp (
    .pattern_i (pattern),
    .text_i    (char_q),
    .req_i     (cmp_req),
    .eq_o      (eq)
  );

  kmp_fail_table #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_PATTERN),
    .AW    (TBL_AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_wr.en),
    .waddr_i (tbl_wr.addr[TBL_AW-1:0]),
    .wdata_i (tbl_wr.data),
    .raddr_i (tbl_raddr[TBL_AW-1:0]),
    .rdata_o (tbl_rdata)
  );

  always_comb begin
    state_d   = state_q;
    mc_d      = mc_q;
    found_d   = found_q;
    tbl_ok_d  = tbl_ok_q;
    char_d    = char_q;
    last_d    = last_q;
    i_d       = i_q;
    k_d       = k_q;
    j_d       = j_q;
    hit_d     = hit_q;
    out_load  = 1'b0;
    tbl_wr    = '0;
    cmp_req.idx_a    = i_q[CNT_W-1:0];
    cmp_req.idx_b    = k_q;
    cmp_req.use_text = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          char_d = s_axis_tdata;
          last_d = s_axis_tlast;
          hit_d  = 1'b0;
          if (!tbl_ok_q) begin
            // entry 0 is always zero; also covers a one-byte pattern
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = '0;
            tbl_wr.data = '0;
            i_d     = LEN_W'(1);
            k_d     = '0;
            state_d = ST_BUILD;
          end else begin
            j_d     = mc_start;
            state_d = ST_MATCH;
          end
        end
      end
      ST_BUILD: begin
        if (i_q >= eff_len) begin
          tbl_ok_d = 1'b1;
          mc_d     = mc_start;
          j_d      = mc_start;
          state_d  = ST_MATCH;
        end else if (!eq && (k_q != '0)) begin
          k_d = tbl_rdata;
        end else begin
          tbl_wr.en   = 1'b1;
          tbl_wr.addr = i_q[CNT_W-1:0];
          tbl_wr.data = kn[CNT_W-1:0];
          k_d = kn[CNT_W-1:0];
          i_d = i_q + LEN_W'(1);
        end
      end
      ST_MATCH: begin
        cmp_req.idx_a    = j_q;
        cmp_req.use_text = 1'b1;
        if (!eq && (j_q != '0)) begin
          j_d = tbl_rdata;
        end else if (jn >= eff_len) begin
          // full occurrence: continue from the last entry's failure value
          hit_d   = 1'b1;
          state_d = ST_RESULT;
        end else begin
          j_d     = jn[CNT_W-1:0];
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (last_q) begin
            mc_d     = '0;
            found_d  = 1'b0;
            tbl_ok_d = 1'b0;
          end else begin
            mc_d    = j_fin;
            found_d = found_q | hit_q;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_acc && (cfg_index_i inside {REG_PAT_LOW, REG_PAT_HIGH, REG_PAT_LEN})) begin
      tbl_ok_d = 1'b0;
    end
  end

  // table read is registered: fetch the entry the next cycle may need
  always_comb begin
    tbl_raddr = j_d - CNT_W'(1);
    if (state_d == ST_BUILD) begin
      tbl_raddr = k_d - CNT_W'(1);
    end else if ((state_d == ST_RESULT) && hit_d) begin
      tbl_raddr = len_m1[CNT_W-1:0];
    end
  end

  assign out_vld_d = out_load | (out_vld_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mc_q      <= '0;
      found_q   <= 1'b0;
      tbl_ok_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mc_q      <= mc_d;
      found_q   <= found_d;
      tbl_ok_q  <= tbl_ok_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    i_q    <= i_d;
    k_q    <= k_d;
    j_q    <= j_d;
    hit_q  <= hit_d;
    if (out_load) begin
      out_hit_q   <= hit_q;
      out_found_q <= found_q | hit_q;
      out_len_q   <= j_fin;
      out_last_q  <= last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_len_q, out_found_q, out_hit_q};
  assign m_axis_tlast  = out_last_q;

endmodule
